@@ src/medp_pkg.sv @@
// ----------------------------------------------------------------------------
// medp_pkg
// Shared types and constants for the matrix element dot product block.
// ----------------------------------------------------------------------------
package medp_pkg;

   localparam int MAX_DIM     = 16;
   localparam int IDX_W       = $clog2(MAX_DIM);
   localparam int ADDR_W      = 2 * IDX_W;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int DATA_W      = 32;
   localparam int SIZE_W      = 5;
   localparam int FUNC_W      = 2;
   localparam int CSR_IDX_W   = 2;

   localparam logic [FUNC_W-1:0] FUNC_WRITE_A = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE_B = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_LEN = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd4;
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_DIM);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic operand_valid;
   } mac_ctrl_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
      return (v > SIZE_MAX) ? SIZE_MAX : v;
   endfunction

endpackage

@@ src/medp_ram.sv @@
// ----------------------------------------------------------------------------
// medp_ram
// Generic single-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module medp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/medp_mac.sv @@
// ----------------------------------------------------------------------------
// medp_mac
// Multiply-accumulate unit: registered product, then wrapping 32-bit sum.
// ----------------------------------------------------------------------------
module medp_mac (
   input  logic                         clock,
   input  logic                         reset,
   input  medp_pkg::mac_ctrl_type       ctrl,
   input  logic [medp_pkg::DATA_W-1:0]  operand_a,
   input  logic [medp_pkg::DATA_W-1:0]  operand_b,
   output logic [medp_pkg::DATA_W-1:0]  acc,
   output logic                         busy
);
   import medp_pkg::*;

   logic [2*DATA_W-1:0] full_prod;
   logic [DATA_W-1:0]   prod_ff, prod_in;
   logic                prod_vld_ff, prod_vld_in;
   logic [DATA_W-1:0]   acc_ff, acc_in;

   always_comb begin
      full_prod   = operand_a * operand_b;
      prod_in     = full_prod[DATA_W-1:0];
      prod_vld_in = ctrl.operand_valid;
      acc_in      = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc  = acc_ff;
   assign busy = prod_vld_ff;

endmodule

@@ src/matrix_element_dot_product.sv @@
// ----------------------------------------------------------------------------
// matrix_element_dot_product
// Stores entries of A and B in two RAMs; a compute transfer walks one row of
// A and one column of B through a multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Write transfers: taken one per cycle while idle, stored at the accepting edge.
// Compute: after acceptance, one read pair per cycle, then multiply,
//   accumulate, drain check and result load (held while the last result is not taken).
//   Out-of-range or zero-length compute: no reads; straight to the result load.
// Next item accepted in the cycle after the result loads, even if not taken.
// Reset (synchronous): sizes return to 4, control idles, RAMs keep contents.
module matrix_element_dot_product (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [medp_pkg::FUNC_W-1:0]     req_func,
   input  logic [medp_pkg::IDX_W-1:0]      req_row_index,
   input  logic [medp_pkg::IDX_W-1:0]      req_col_index,
   input  logic signed [medp_pkg::DATA_W-1:0] req_entry_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [medp_pkg::IDX_W-1:0]      rsp_out_row,
   output logic [medp_pkg::IDX_W-1:0]      rsp_out_col,
   output logic signed [medp_pkg::DATA_W-1:0] rsp_product_value,
   output logic                            rsp_bad_index,
   input  logic                            csr_we,
   input  logic [medp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [medp_pkg::SIZE_W-1:0]     csr_wdata
);
   import medp_pkg::*;

   logic [SIZE_W-1:0] rows_a_ff, cols_b_ff, inner_len_ff;
   logic [SIZE_W-1:0] m_eff, n_eff, k_eff;

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] k_ff, k_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  row_ff, row_in, col_ff, col_in;
   logic              bad_ff, bad_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_bad_ff, rsp_bad_in;

   logic              accept, issue;
   logic              we_a, we_b;
   logic [ADDR_W-1:0] addr_a, addr_b;
   logic [DATA_W-1:0] rdata_a, rdata_b, acc;
   logic              mac_busy;
   mac_ctrl_type      mac_ctrl;
   logic              req_bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= SIZE_RESET;
         cols_b_ff    <= SIZE_RESET;
         inner_len_ff <= SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS_A:    rows_a_ff    <= csr_wdata;
            CSR_COLS_B:    cols_b_ff    <= csr_wdata;
            CSR_INNER_LEN: inner_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign m_eff = eff_size(rows_a_ff);
   assign n_eff = eff_size(cols_b_ff);
   assign k_eff = eff_size(inner_len_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign issue     = (state_ff == ST_ISSUE);

   assign req_bad = !(({1'b0, req_row_index} < m_eff) && ({1'b0, req_col_index} < n_eff));

   assign we_a = accept && (req_func == FUNC_WRITE_A) &&
                 ({1'b0, req_row_index} < m_eff) && ({1'b0, req_col_index} < k_eff);
   assign we_b = accept && (req_func == FUNC_WRITE_B) &&
                 ({1'b0, req_row_index} < k_eff) && ({1'b0, req_col_index} < n_eff);

   assign addr_a = issue ? {row_ff, k_ff[IDX_W-1:0]} : {req_row_index, req_col_index};
   assign addr_b = issue ? {k_ff[IDX_W-1:0], col_ff} : {req_row_index, req_col_index};

   always_comb begin
      state_in       = state_ff;
      k_in           = k_ff;
      rd_vld_in      = 1'b0;
      row_in         = row_ff;
      col_in         = col_ff;
      bad_in         = bad_ff;
      mac_ctrl.clear = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_row_in     = rsp_row_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_bad_in     = rsp_bad_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_func == FUNC_COMPUTE)) begin
               row_in         = req_row_index;
               col_in         = req_col_index;
               bad_in         = req_bad;
               k_in           = '0;
               mac_ctrl.clear = 1'b1;
               state_in       = (req_bad || (k_eff == '0)) ? ST_DONE : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            rd_vld_in = 1'b1;
            k_in      = k_ff + 1'b1;
            if (k_in == k_eff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !mac_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_col_in   = col_ff;
               rsp_value_in = acc;
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      mac_ctrl.operand_valid = rd_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff         <= k_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      bad_ff       <= bad_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   medp_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store_a (
      .clock (clock),
      .we    (we_a),
      .addr  (addr_a),
      .wdata (req_entry_value),
      .rdata (rdata_a)
   );

   medp_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store_b (
      .clock (clock),
      .we    (we_b),
      .addr  (addr_b),
      .wdata (req_entry_value),
      .rdata (rdata_b)
   );

   medp_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .operand_a (rdata_a),
      .operand_b (rdata_b),
      .acc       (acc),
      .busy      (mac_busy)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_bad_index     = rsp_bad_ff;

endmodule

@@ src/medp_checker.sv @@
// ----------------------------------------------------------------------------
// medp_checker
// Port-level checks on the matrix element dot product block.
// ----------------------------------------------------------------------------
module medp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [medp_pkg::FUNC_W-1:0]      req_func,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [medp_pkg::DATA_W-1:0]      rsp_product_value,
   input logic                             rsp_bad_index
);
   import medp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_product_value))
      else $error("result changed while stalled");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_index |-> rsp_product_value == '0)
      else $error("bad index result with nonzero value");

   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_COMPUTE |=> !req_ready)
      else $error("ready after compute transfer");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without compute in progress");

endmodule

bind matrix_element_dot_product medp_checker u_medp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_func          (req_func),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_product_value (rsp_product_value),
   .rsp_bad_index     (rsp_bad_index)
);

@@ dv/tb_matrix_element_dot_product.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_element_dot_product
// Loads entries of A and B, requests product elements and checks every
// returned element against a local predictor of the stores and the sizes.
// Covers directed corner cases, zero and saturated sizes, a long receiver
// hold-off and random sweeps over many size settings.
// ----------------------------------------------------------------------------
module tb_matrix_element_dot_product;
   import medp_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int DRAIN_CYCLES   = 24;
   localparam int LONG_HOLD      = 200;
   localparam int TIMEOUT_CYCLES = 500_000;
   localparam int PHASE_ITEMS    = 40;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;

   typedef struct packed {
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [DATA_W-1:0] value;
      logic                     bad;
   } product_elem_type;

   logic                        clock           = 1'b0;
   logic                        reset           = 1'b1;
   logic                        req_valid       = 1'b0;
   logic                        req_ready;
   logic [FUNC_W-1:0]           req_func        = '0;
   logic [IDX_W-1:0]            req_row_index   = '0;
   logic [IDX_W-1:0]            req_col_index   = '0;
   logic signed [DATA_W-1:0]    req_entry_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready       = 1'b0;
   logic [IDX_W-1:0]            rsp_out_row;
   logic [IDX_W-1:0]            rsp_out_col;
   logic signed [DATA_W-1:0]    rsp_product_value;
   logic                        rsp_bad_index;
   logic                        csr_we          = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index       = '0;
   logic [SIZE_W-1:0]           csr_wdata       = '0;

   logic [SIZE_W-1:0] size_rows  = SIZE_RESET;
   logic [SIZE_W-1:0] size_cols  = SIZE_RESET;
   logic [SIZE_W-1:0] size_inner = SIZE_RESET;
   logic [DATA_W-1:0] a_store [STORE_DEPTH];
   logic [DATA_W-1:0] b_store [STORE_DEPTH];
   bit                a_written [STORE_DEPTH];
   bit                b_written [STORE_DEPTH];

   product_elem_type pending_products [$];
   int               effective_transfers = 0;
   int               mismatch_count      = 0;
   int               hold_requests       = 0;
   bit               idling_on           = 1'b1;

   matrix_element_dot_product uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_entry_value   (req_entry_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_bad_index     (rsp_bad_index),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
      return (v > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : v;
   endfunction

   // advance the stores and queue the product element one transfer causes
   function automatic void apply_matrix_op(input logic [FUNC_W-1:0] f,
                                           input logic [IDX_W-1:0] row,
                                           input logic [IDX_W-1:0] col,
                                           input logic [DATA_W-1:0] val);
      logic [SIZE_W-1:0] m;
      logic [SIZE_W-1:0] n;
      logic [SIZE_W-1:0] k;
      logic [DATA_W-1:0] acc;
      product_elem_type  elem;
      m = clamp_dim(size_rows);
      n = clamp_dim(size_cols);
      k = clamp_dim(size_inner);
      case (f)
         FUNC_WRITE_A: begin
            if (row < m && col < k) begin
               a_store[{row, col}]   = val;
               a_written[{row, col}] = 1'b1;
               effective_transfers++;
            end
         end
         FUNC_WRITE_B: begin
            if (row < k && col < n) begin
               b_store[{row, col}]   = val;
               b_written[{row, col}] = 1'b1;
               effective_transfers++;
            end
         end
         FUNC_COMPUTE: begin
            elem.row = row;
            elem.col = col;
            elem.bad = !(row < m && col < n);
            acc      = '0;
            if (!elem.bad) begin
               for (int i = 0; i < k; i++)
                  acc += a_store[{row, IDX_W'(i)}] * b_store[{IDX_W'(i), col}];
            end
            elem.value = acc;
            pending_products.push_back(elem);
            effective_transfers++;
         end
         default: ;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] rand_entry();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return '1;
         3:       return '0;
         4, 5:    return DATA_W'($urandom_range(0, 40)) - DATA_W'(20);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] pick_index(input logic [SIZE_W-1:0] lim);
      if (lim != 0 && $urandom_range(0, 4) != 0)
         return IDX_W'($urandom_range(0, lim - 1));
      return IDX_W'($urandom_range(0, MAX_DIM - 1));
   endfunction

   task automatic send_item(input logic [FUNC_W-1:0] f,
                            input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col,
                            input logic [DATA_W-1:0] val);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= f;
      req_row_index   <= row;
      req_col_index   <= col;
      req_entry_value <= val;
      do @(posedge clock); while (!req_ready);
      apply_matrix_op(f, row, col, val);
   endtask

   // hold off new transfers until every product element is back
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_sizes(input logic [SIZE_W-1:0] rows,
                            input logic [SIZE_W-1:0] cols,
                            input logic [SIZE_W-1:0] inner);
      csr_we    <= 1'b1;
      csr_index <= CSR_UNUSED;
      csr_wdata <= SIZE_W'($urandom());
      @(posedge clock);
      csr_index <= CSR_ROWS_A;
      csr_wdata <= rows;
      @(posedge clock);
      csr_index <= CSR_COLS_B;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= CSR_INNER_LEN;
      csr_wdata <= inner;
      @(posedge clock);
      csr_we     <= 1'b0;
      size_rows  = rows;
      size_cols  = cols;
      size_inner = inner;
      @(posedge clock);
   endtask

   // write any operand of the element that has not been stored yet
   task automatic fill_operands(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
      logic [SIZE_W-1:0] k;
      k = clamp_dim(size_inner);
      if (row < clamp_dim(size_rows) && col < clamp_dim(size_cols)) begin
         for (int i = 0; i < k; i++) begin
            if (!a_written[{row, IDX_W'(i)}])
               send_item(FUNC_WRITE_A, row, IDX_W'(i), rand_entry());
            if (!b_written[{IDX_W'(i), col}])
               send_item(FUNC_WRITE_B, IDX_W'(i), col, rand_entry());
         end
      end
   endtask

   task automatic test_directed_basics();
      send_item(FUNC_WRITE_A, 4'd0, 4'd0, 32'h7FFF_FFFF);
      send_item(FUNC_WRITE_A, 4'd0, 4'd1, 32'h8000_0000);
      send_item(FUNC_WRITE_A, 4'd0, 4'd2, 32'hFFFF_FFFF);
      send_item(FUNC_WRITE_A, 4'd0, 4'd3, 32'h0000_0001);
      send_item(FUNC_WRITE_B, 4'd0, 4'd0, 32'h0000_0002);
      send_item(FUNC_WRITE_B, 4'd1, 4'd0, 32'h8000_0000);
      send_item(FUNC_WRITE_B, 4'd2, 4'd0, 32'hFFFF_FFFF);
      send_item(FUNC_WRITE_B, 4'd3, 4'd0, 32'h7FFF_FFFF);
      send_item(FUNC_COMPUTE, 4'd0, 4'd0, 32'h0);
      send_item(FUNC_WRITE_A, 4'd0, 4'd0, 32'h8000_0000);
      send_item(FUNC_COMPUTE, 4'd0, 4'd0, 32'hFFFF_FFFF);
      send_item(FUNC_COMPUTE, 4'd4, 4'd0, 32'h0);
      send_item(FUNC_COMPUTE, 4'd0, 4'd4, 32'h0);
      send_item(FUNC_COMPUTE, 4'd15, 4'd15, 32'h0);
      send_item(FUNC_UNUSED, 4'd15, 4'd15, 32'hFFFF_FFFF);
      send_item(FUNC_WRITE_A, 4'd4, 4'd0, 32'h1234_5678);
      send_item(FUNC_WRITE_A, 4'd0, 4'd4, 32'h1234_5678);
      send_item(FUNC_WRITE_B, 4'd4, 4'd0, 32'h1234_5678);
      send_item(FUNC_COMPUTE, 4'd0, 4'd0, 32'h0);
      drain_block();
   endtask

   task automatic test_zero_sizes();
      set_sizes(5'd0, 5'd4, 5'd4);
      send_item(FUNC_COMPUTE, 4'd0, 4'd0, 32'h0);
      send_item(FUNC_WRITE_A, 4'd0, 4'd0, 32'h5555_5555);
      drain_block();
      set_sizes(5'd4, 5'd0, 5'd4);
      send_item(FUNC_COMPUTE, 4'd0, 4'd0, 32'h0);
      send_item(FUNC_WRITE_B, 4'd0, 4'd0, 32'hAAAA_AAAA);
      drain_block();
      set_sizes(5'd4, 5'd4, 5'd0);
      send_item(FUNC_COMPUTE, 4'd0, 4'd0, 32'h0);
      send_item(FUNC_COMPUTE, 4'd3, 4'd3, 32'h0);
      send_item(FUNC_WRITE_A, 4'd0, 4'd0, 32'h5555_5555);
      drain_block();
      set_sizes(5'd4, 5'd4, 5'd4);
      send_item(FUNC_COMPUTE, 4'd0, 4'd0, 32'h0);
      drain_block();
   endtask

   task automatic test_receiver_backpressure();
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      hold_requests <= hold_requests + 1;
      repeat (12) begin
         row = IDX_W'($urandom_range(0, 3));
         col = IDX_W'($urandom_range(0, 3));
         fill_operands(row, col);
         send_item(FUNC_COMPUTE, row, col, rand_entry());
      end
      drain_block();
   endtask

   task automatic run_random_items(input int count);
      int                target;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      int unsigned       pick;
      target = effective_transfers + count;
      while (effective_transfers < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_item(FUNC_WRITE_A, pick_index(clamp_dim(size_rows)),
                      pick_index(clamp_dim(size_inner)), rand_entry());
         end else if (pick < 60) begin
            send_item(FUNC_WRITE_B, pick_index(clamp_dim(size_inner)),
                      pick_index(clamp_dim(size_cols)), rand_entry());
         end else if (pick < 95) begin
            row = pick_index(clamp_dim(size_rows));
            col = pick_index(clamp_dim(size_cols));
            fill_operands(row, col);
            send_item(FUNC_COMPUTE, row, col, rand_entry());
         end else begin
            send_item(FUNC_UNUSED, IDX_W'($urandom()), IDX_W'($urandom()), rand_entry());
         end
      end
   endtask

   task automatic test_random_sweep();
      logic [SIZE_W-1:0] rows_list  [8] = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd17, 5'd0, 5'd6, 5'd5};
      logic [SIZE_W-1:0] cols_list  [8] = '{5'd16, 5'd1, 5'd31, 5'd7, 5'd2, 5'd5, 5'd0, 5'd5};
      logic [SIZE_W-1:0] inner_list [8] = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd30, 5'd5, 5'd3, 5'd0};
      for (int p = 0; p < 11; p++) begin
         drain_block();
         if (p < 8)
            set_sizes(rows_list[p], cols_list[p], inner_list[p]);
         else if (p < 10)
            set_sizes(SIZE_W'($urandom()), SIZE_W'($urandom()), SIZE_W'($urandom()));
         else begin
            idling_on = 1'b0;
            set_sizes(5'd16, 5'd16, 5'd16);
         end
         run_random_items(PHASE_ITEMS);
      end
   endtask

   initial begin : rsp_side
      int served;
      served = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != served) begin
            served++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      product_elem_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_products.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected product element: row %0d col %0d value %0d bad %0b",
                        rsp_out_row, rsp_out_col, rsp_product_value, rsp_bad_index);
         end else begin
            want = pending_products.pop_front();
            if (rsp_out_row !== want.row || rsp_out_col !== want.col ||
                rsp_product_value !== want.value || rsp_bad_index !== want.bad) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"wrong product element: expected row %0d col %0d value %0d",
                            " bad %0b, got row %0d col %0d value %0d bad %0b"},
                           want.row, want.col, want.value, want.bad, rsp_out_row,
                           rsp_out_col, rsp_product_value, rsp_bad_index);
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("matrix_element_dot_product: mismatch");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_zero_sizes();
      test_receiver_backpressure();
      test_random_sweep();
      drain_block();
      if (mismatch_count == 0 && pending_products.size() == 0)
         $display("matrix_element_dot_product: match");
      else
         $display("matrix_element_dot_product: mismatch");
      $finish;
   end

endmodule
